/* src/lsos_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsos_pkg
// Shared types, constants and the arctangent table of the steering block.
// ----------------------------------------------------------------------------
package lsos_pkg;

	localparam int SQRT_STEPS = 24;

	localparam logic signed [27:0] PI_Q24         = 28'sd52707179;
	localparam logic signed [27:0] HALF_PI_Q24    = 28'sd26353589;
	localparam logic signed [27:0] QUARTER_PI_Q24 = 28'sd13176795;
	localparam logic signed [33:0] KINV_Q30       = 34'sd652032874;

	typedef enum logic [2:0] {
		REG_ANGLE_START  = 3'd0,
		REG_ANGLE_STEP   = 3'd1,
		REG_DETECT_RANGE = 3'd2,
		REG_HALF_WIDTH   = 3'd3,
		REG_BASE_SPEED   = 3'd4,
		REG_SLOW_GAIN    = 3'd5,
		REG_TURN_GAIN    = 3'd6,
		REG_SPEED_LIMIT  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] angle_start;
		logic signed [15:0] angle_step;
		logic [15:0]        detect_range;
		logic [15:0]        half_width;
		logic [13:0]        base_speed;
		logic [13:0]        slow_gain;
		logic [12:0]        turn_gain;
		logic [13:0]        speed_limit;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ANG, ST_CINIT, ST_ROT, ST_MUL, ST_CHK, ST_SEL, ST_SQINIT,
		ST_SQ, ST_AINIT, ST_ATAN, ST_PHI, ST_PROD, ST_OUT
	} state_t;

	typedef struct packed {
		logic       take;
		logic       ang;
		logic       cinit;
		logic       ainit;
		logic       citer;
		logic       cmul;
		logic       chk;
		logic       sel;
		logic       sqinit;
		logic       sqiter;
		logic       phi;
		logic       prod;
		logic       out_load;
		logic [4:0] step;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} sts_t;

	function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
		logic signed [27:0] v;
		unique case (i)
			5'd0:  v = 28'sd13176795;
			5'd1:  v = 28'sd7778716;
			5'd2:  v = 28'sd4110060;
			5'd3:  v = 28'sd2086331;
			5'd4:  v = 28'sd1047214;
			5'd5:  v = 28'sd524117;
			5'd6:  v = 28'sd262123;
			5'd7:  v = 28'sd131069;
			5'd8:  v = 28'sd65536;
			5'd9:  v = 28'sd32768;
			5'd10: v = 28'sd16384;
			5'd11: v = 28'sd8192;
			5'd12: v = 28'sd4096;
			5'd13: v = 28'sd2048;
			5'd14: v = 28'sd1024;
			5'd15: v = 28'sd512;
			5'd16: v = 28'sd256;
			5'd17: v = 28'sd128;
			5'd18: v = 28'sd64;
			5'd19: v = 28'sd32;
			default: v = 28'sd0;
		endcase
		return v;
	endfunction

endpackage

/* src/lsos_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsos_dp
// Datapath: ray angle, shared CORDIC, square root, scan state and result.
// ----------------------------------------------------------------------------
module lsos_dp import lsos_pkg::*; #(
	parameter int MAX_RAYS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // fwd_speed[14:0], yaw_rate[29:15]
	output logic [1:0]  m_tuser    // avoiding, turn_left
);

	logic [15:0]        range_q;
	logic [11:0]        idx_q;
	logic               last_q;
	logic signed [15:0] ang_q;
	logic               inr_q;
	logic signed [33:0] x_q, y_q;
	logic signed [27:0] z_q;
	logic               neg_q;
	logic signed [50:0] pc_q, ps_q;
	logic               seen_q, blocked_q;
	logic [15:0]        fr_q, er_q;
	logic signed [15:0] fa_q, ea_q;
	logic signed [15:0] alpha_q;
	logic               tl_q, byp_q;
	logic [31:0]        rr_q, hh_q;
	logic [47:0]        v_q, res_q, bit_q;
	logic signed [27:0] phi_q;
	logic signed [42:0] prod_q;
	logic [40:0]        magp_q;
	logic               ovalid_q;
	logic [14:0]        lin_q, angv_q;
	logic               avoid_q, tlo_q;
	logic               state_rot_mode;
	logic               rot_mode_q;

	logic signed [29:0] angw;
	logic signed [15:0] ang_sat;
	logic signed [27:0] z0, zf;
	logic signed [33:0] dx, dy, cval, sabs;
	logic signed [27:0] at;
	logic               dir;
	logic [16:0]        fabs, eabs;
	logic [47:0]        sq_add;
	logic signed [27:0] half, phi_d;
	logic [27:0]        phi_abs;
	logic signed [43:0] diff;
	logic signed [38:0] basev;
	logic [19:0]        lin_w;
	logic [16:0]        mag_w;
	logic [13:0]        lin_c, mag_c;
	logic signed [51:0] detw, hww;

	always_comb begin
		angw = 30'(cfg.angle_start) + cfg.angle_step * $signed({1'b0, idx_q});
		if (angw > 30'sd32767) begin
			ang_sat = 16'sh7fff;
		end else if (angw < -30'sd32768) begin
			ang_sat = 16'sh8000;
		end else begin
			ang_sat = angw[15:0];
		end
		z0 = 28'(ang_q) <<< 11;
		if (z0 > HALF_PI_Q24) begin
			zf = z0 - PI_Q24;
		end else if (z0 < -HALF_PI_Q24) begin
			zf = z0 + PI_Q24;
		end else begin
			zf = z0;
		end
		dx = y_q >>> cmd.step;
		dy = x_q >>> cmd.step;
		at = atan_q24(cmd.step);
		dir = cmd.ainit ? 1'b0 : ((state_rot_mode) ? (z_q >= 0) : !(y_q > 0));
		cval = neg_q ? -x_q : x_q;
		sabs = (y_q < 0) ? -y_q : y_q;
		detw = 52'(signed'({1'b0, cfg.detect_range, 30'b0}));
		hww  = 52'(signed'({1'b0, cfg.half_width, 30'b0}));
		fabs = (fa_q < 0) ? 17'(-17'(fa_q)) : 17'(fa_q);
		eabs = (ea_q < 0) ? 17'(-17'(ea_q)) : 17'(ea_q);
		sq_add = res_q + bit_q;
		half = byp_q ? QUARTER_PI_Q24 : z_q;
		phi_d = blocked_q ? ((tl_q ? half : -half) + (28'(alpha_q) <<< 11)) : 28'sd0;
		phi_abs = (phi_q < 0) ? 28'(-phi_q) : 28'(phi_q);
		basev = signed'({1'b0, cfg.base_speed, 24'b0});
		diff = 44'(basev) - 44'(prod_q);
		lin_w = (44'(prod_q) < 44'(basev)) ? diff[43:24] : 20'd0;
		lin_c = (lin_w > 20'(cfg.speed_limit)) ? cfg.speed_limit : lin_w[13:0];
		mag_w = magp_q[40:24];
		mag_c = (mag_w > 17'(cfg.speed_limit)) ? cfg.speed_limit : mag_w[13:0];
	end

	assign state_rot_mode = rot_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_mode_q <= 1'b1;
		end else if (cmd.cinit) begin
			rot_mode_q <= 1'b1;
		end else if (cmd.ainit) begin
			rot_mode_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			range_q <= s_tdata[15:0];
			idx_q   <= s_tdata[27:16];
			last_q  <= s_tlast;
		end
		if (cmd.ang) begin
			ang_q <= ang_sat;
			inr_q <= (32'(idx_q) < 32'(MAX_RAYS));
		end
		if (cmd.cinit) begin
			x_q   <= KINV_Q30;
			y_q   <= '0;
			z_q   <= zf;
			neg_q <= (z0 > HALF_PI_Q24) || (z0 < -HALF_PI_Q24);
		end else if (cmd.ainit) begin
			x_q <= 34'(res_q[23:0]);
			y_q <= 34'({cfg.half_width, 8'b0});
			z_q <= '0;
		end else if (cmd.citer) begin
			if (dir) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		if (cmd.cmul) begin
			pc_q <= $signed({1'b0, range_q}) * cval;
			ps_q <= $signed({1'b0, range_q}) * sabs;
		end
		if (cmd.sel) begin
			if (fabs > eabs) begin
				alpha_q <= ea_q;
				tl_q <= 1'b1;
				rr_q <= er_q * er_q;
				byp_q <= (er_q == 16'd0) || (cfg.half_width > er_q);
			end else begin
				alpha_q <= fa_q;
				tl_q <= 1'b0;
				rr_q <= fr_q * fr_q;
				byp_q <= (fr_q == 16'd0) || (cfg.half_width > fr_q);
			end
			hh_q <= cfg.half_width * cfg.half_width;
		end
		if (cmd.sqinit) begin
			v_q   <= byp_q ? 48'd0 : {rr_q - hh_q, 16'b0};
			res_q <= '0;
			bit_q <= 48'd1 << 46;
		end else if (cmd.sqiter) begin
			if (v_q >= sq_add) begin
				v_q   <= v_q - sq_add;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.phi) begin
			phi_q <= phi_d;
		end
		if (cmd.prod) begin
			prod_q <= $signed({1'b0, cfg.slow_gain}) * 43'(phi_q);
			magp_q <= cfg.turn_gain * phi_abs;
		end
		if (cmd.out_load) begin
			lin_q   <= 15'(lin_c);
			angv_q  <= (blocked_q && !tl_q) ? 15'(-15'(mag_c)) : 15'(mag_c);
			avoid_q <= blocked_q;
			tlo_q   <= blocked_q && tl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			blocked_q <= 1'b0;
			fr_q      <= '0;
			fa_q      <= '0;
			er_q      <= '0;
			ea_q      <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cmd.chk && inr_q) begin
				if (range_q <= cfg.detect_range) begin
					if (!seen_q) begin
						fr_q   <= range_q;
						fa_q   <= ang_q;
						seen_q <= 1'b1;
					end
					er_q <= range_q;
					ea_q <= ang_q;
				end
				if ((52'(pc_q) <= detw) && (52'(ps_q) < hww)) begin
					blocked_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				seen_q    <= 1'b0;
				blocked_q <= 1'b0;
				fr_q      <= '0;
				fa_q      <= '0;
				er_q      <= '0;
				ea_q      <= '0;
				ovalid_q  <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign sts.last     = last_q;
	assign sts.out_free = !ovalid_q || m_tready;
	assign m_tvalid     = ovalid_q;
	assign m_tdata      = {2'b00, angv_q, lin_q};
	assign m_tuser      = {tlo_q, avoid_q};

endmodule

/* src/lsos_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsos_ctrl
// Sequencer for one ray and for the end-of-scan command computation.
// ----------------------------------------------------------------------------
module lsos_ctrl import lsos_pkg::*; #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic [4:0] cnt_q;
	logic       cdone, sdone, iter;

	assign cdone = (cnt_q == 5'(CORDIC_STEPS - 1));
	assign sdone = (cnt_q == 5'(SQRT_STEPS - 1));
	assign iter  = (state_q == ST_ROT) || (state_q == ST_SQ) || (state_q == ST_ATAN);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_ANG;
			ST_ANG:    state_d = ST_CINIT;
			ST_CINIT:  state_d = ST_ROT;
			ST_ROT:    if (cdone) state_d = ST_MUL;
			ST_MUL:    state_d = ST_CHK;
			ST_CHK:    state_d = sts.last ? ST_SEL : ST_IDLE;
			ST_SEL:    state_d = ST_SQINIT;
			ST_SQINIT: state_d = ST_SQ;
			ST_SQ:     if (sdone) state_d = ST_AINIT;
			ST_AINIT:  state_d = ST_ATAN;
			ST_ATAN:   if (cdone) state_d = ST_PHI;
			ST_PHI:    state_d = ST_PROD;
			ST_PROD:   state_d = ST_OUT;
			ST_OUT:    if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd          = '0;
		cmd.take     = s_tready && s_tvalid;
		cmd.ang      = (state_q == ST_ANG);
		cmd.cinit    = (state_q == ST_CINIT);
		cmd.ainit    = (state_q == ST_AINIT);
		cmd.citer    = (state_q == ST_ROT) || (state_q == ST_ATAN);
		cmd.cmul     = (state_q == ST_MUL);
		cmd.chk      = (state_q == ST_CHK);
		cmd.sel      = (state_q == ST_SEL);
		cmd.sqinit   = (state_q == ST_SQINIT);
		cmd.sqiter   = (state_q == ST_SQ);
		cmd.phi      = (state_q == ST_PHI);
		cmd.prod     = (state_q == ST_PROD);
		cmd.out_load = (state_q == ST_OUT) && sts.out_free;
		cmd.step     = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (iter && (state_d == state_q)) ? cnt_q + 5'd1 : 5'd0;
		end
	end

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == ST_ANG)
		else $error("accepted beat did not start the angle step");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT || state_q == ST_ATAN) |-> cnt_q < 5'(CORDIC_STEPS))
		else $error("CORDIC step count overran");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free && sts.last)
		else $error("result loaded into a full output register");

endmodule

/* src/laser_scan_obstacle_steering.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_scan_obstacle_steering
// Reactive steering command from one laser scan, one ray per beat.
// ----------------------------------------------------------------------------
// Each ray beat is processed by the iterative sine/cosine CORDIC that rotates
// the ray angle; no new ray is taken until that beat is through. A beat marked
// last then runs a 24-step square root and the arctangent run of the same
// CORDIC unit before the command beat is registered. The next ray is taken
// while a command beat waits at the output.
module laser_scan_obstacle_steering import lsos_pkg::*; #(
	parameter int MAX_RAYS     = 4096,
	parameter int CORDIC_STEPS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // range_mm[15:0], ray_index[27:16]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // fwd_speed[14:0], yaw_rate[29:15]
	output logic [1:0]  m_tuser    // avoiding[0], turn_left[1]
);

	cfg_t     cfg_q;
	cmd_t     cmd;
	sts_t     sts;
	reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_start  <= -16'sd12868;
			cfg_q.angle_step   <= 16'sd143;
			cfg_q.detect_range <= 16'd3000;
			cfg_q.half_width   <= 16'd420;
			cfg_q.base_speed   <= 14'd1638;
			cfg_q.slow_gain    <= 14'd410;
			cfg_q.turn_gain    <= 13'd2867;
			cfg_q.speed_limit  <= 14'd8192;
		end else if (psel && penable && pwrite && pready) begin
			unique case (ridx)
				REG_ANGLE_START:  cfg_q.angle_start  <= pwdata[15:0];
				REG_ANGLE_STEP:   cfg_q.angle_step   <= pwdata[15:0];
				REG_DETECT_RANGE: cfg_q.detect_range <= pwdata[15:0];
				REG_HALF_WIDTH:   cfg_q.half_width   <= pwdata[15:0];
				REG_BASE_SPEED:   cfg_q.base_speed   <= pwdata[13:0];
				REG_SLOW_GAIN:    cfg_q.slow_gain    <= pwdata[13:0];
				REG_TURN_GAIN:    cfg_q.turn_gain    <= pwdata[12:0];
				REG_SPEED_LIMIT:  cfg_q.speed_limit  <= pwdata[13:0];
				default:          cfg_q.speed_limit  <= cfg_q.speed_limit;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_ANGLE_START:  prdata = 32'({cfg_q.angle_start});
			REG_ANGLE_STEP:   prdata = 32'({cfg_q.angle_step});
			REG_DETECT_RANGE: prdata = 32'(cfg_q.detect_range);
			REG_HALF_WIDTH:   prdata = 32'(cfg_q.half_width);
			REG_BASE_SPEED:   prdata = 32'(cfg_q.base_speed);
			REG_SLOW_GAIN:    prdata = 32'(cfg_q.slow_gain);
			REG_TURN_GAIN:    prdata = 32'(cfg_q.turn_gain);
			REG_SPEED_LIMIT:  prdata = 32'(cfg_q.speed_limit);
			default:          prdata = '0;
		endcase
	end

	lsos_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsos_dp #(
		.MAX_RAYS(MAX_RAYS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
